FILE: sv/assert_macros.svh
// Assertion macros shared by the timed playlist sequencer RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A trigger whose consequence must hold on the following clock edge.
`define TPS_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: sv/tps_pkg.sv
// Shared types, codes and constants for the timed playlist sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tps_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int HARD_LIMIT    = 256;
    localparam logic [31:0] DWELL_MAX_S = 32'd4294967;
    localparam logic [31:0] MS_PER_S    = 32'd1000;
    localparam int RESQ_DEPTH    = 3;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_CLEAR = 3'd1,
        ACT_START = 3'd2,
        ACT_STOP  = 3'd3,
        ACT_TICK  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_SATURATED = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic [15:0] plugin_id;
        logic [31:0] duration_s;
        logic        clear_table;
    } t_in;

    typedef struct packed {
        logic        switched;
        logic [15:0] current_plugin;
        logic [7:0]  position;
        logic        running;
        logic [8:0]  slot_count;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic [15:0] plugin_id;
        logic [31:0] dwell_ms;
    } t_slot;

    // Result fields known at the end of the processing cycle; the plugin id
    // is not stored here but comes from the registered slot RAM read.
    typedef struct packed {
        logic        switched;
        logic [7:0]  position;
        logic        running;
        logic [8:0]  slot_count;
        logic [1:0]  status;
        logic        table_nz;
    } t_meta;

    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tps_slot_ram.sv
// Slot table RAM: one write port, one registered read port with write forwarding.
// Depends on tps_pkg for the address width helper.
`default_nettype none

module tps_slot_ram #(
    parameter int ENTRIES = tps_pkg::DEPTH_DEFAULT,
    parameter int WIDTH   = $bits(tps_pkg::t_slot),
    localparam int AW     = tps_pkg::addr_w(ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    import tps_pkg::*;

    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // A slot written in the same cycle is seen by the read at once.
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/tps_ctrl.sv
// Sequencer control: position, run state and timing, one word per cycle whenever i_fire is raised.
// Depends on tps_pkg; drives the slot RAM held at the top level.
`default_nettype none
`include "assert_macros.svh"

module tps_ctrl #(
    parameter int ENTRIES = tps_pkg::DEPTH_DEFAULT,
    localparam int AW     = tps_pkg::addr_w(ENTRIES)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire tps_pkg::t_in   i_item,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output tps_pkg::t_slot      o_wdata,
    output logic [AW-1:0]       o_raddr,
    input  wire tps_pkg::t_slot i_rdata,
    output logic                o_res_valid,
    output tps_pkg::t_out       o_res
);
    import tps_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_index, n_index;
    logic          r_active, n_active;
    logic [31:0]   r_last_ms, n_last_ms;
    logic          r_res_valid;
    t_meta         r_meta;

    logic          full;
    logic          saturate;
    logic [31:0]   dwell_s;
    logic [31:0]   elapsed;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_inc;
    logic          switched;
    t_status       status;

    assign full     = (r_count == CW'(ENTRIES));
    assign saturate = (i_item.duration_s > DWELL_MAX_S);
    assign dwell_s  = saturate ? DWELL_MAX_S : i_item.duration_s;
    assign elapsed  = i_item.now_ms - r_last_ms;
    assign idx_ext  = CW'(r_index);
    assign idx_inc  = idx_ext + CW'(1);

    assign o_waddr            = r_count[AW-1:0];
    assign o_wdata.plugin_id  = i_item.plugin_id;
    assign o_wdata.dwell_ms   = dwell_s * MS_PER_S;

    always_comb begin
        n_count   = r_count;
        n_index   = r_index;
        n_active  = r_active;
        n_last_ms = r_last_ms;
        switched  = 1'b0;
        status    = ST_OK;
        o_we      = 1'b0;
        if (i_fire) begin
            case (t_action'(i_item.action))
                ACT_ADD: begin
                    if (full) begin
                        status = ST_FULL;
                    end else begin
                        if (saturate) begin
                            status = ST_SATURATED;
                        end
                        o_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                ACT_CLEAR: begin
                    n_index  = '0;
                    n_active = 1'b0;
                    if (i_item.clear_table) begin
                        n_count = '0;
                    end
                end
                ACT_START: begin
                    if (r_count == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        n_index   = '0;
                        n_last_ms = i_item.now_ms;
                        n_active  = 1'b1;
                        switched  = 1'b1;
                    end
                end
                ACT_STOP: begin
                    n_active = 1'b0;
                end
                ACT_TICK: begin
                    if (r_active && (r_count != '0)) begin
                        if (idx_ext >= r_count) begin
                            n_index   = '0;
                            n_last_ms = i_item.now_ms;
                        end else if (elapsed >= i_rdata.dwell_ms) begin
                            n_index   = (idx_inc == r_count) ? '0 : idx_inc[AW-1:0];
                            n_last_ms = i_item.now_ms;
                            switched  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The RAM reads the next current slot every cycle, so its output always
    // belongs to the position register.
    assign o_raddr = n_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_index     <= '0;
            r_active    <= 1'b0;
            r_last_ms   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_index     <= n_index;
            r_active    <= n_active;
            r_last_ms   <= n_last_ms;
            r_res_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_meta.switched   <= switched;
            r_meta.position   <= 8'(n_index);
            r_meta.running    <= n_active;
            r_meta.slot_count <= 9'(n_count);
            r_meta.status     <= status;
            r_meta.table_nz   <= (n_count != '0);
        end
    end

    assign o_res_valid           = r_res_valid;
    assign o_res.switched        = r_meta.switched;
    assign o_res.current_plugin  = r_meta.table_nz ? i_rdata.plugin_id : 16'd0;
    assign o_res.position        = r_meta.position;
    assign o_res.running         = r_meta.running;
    assign o_res.slot_count      = r_meta.slot_count;
    assign o_res.status          = r_meta.status;

    `TPS_ASSERT(a_index_in_table, i_clk, i_rst_n, (r_count == '0) || (idx_ext < r_count), "position outside the slot table")
    `TPS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(ENTRIES), "slot count above capacity")
    `TPS_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_fire && (i_item.action == ACT_START) && (r_count != '0), r_active && (r_index == '0) && o_res_valid && o_res.switched, "start did not run from slot zero")

endmodule

`default_nettype wire

FILE: sv/tps_result_q.sv
// Three-word result queue that decouples the sequencer from output back-pressure.
// Depends on tps_pkg for the result word type and queue depth.
`default_nettype none
`include "assert_macros.svh"

module tps_result_q (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tps_pkg::t_out i_push_item,
    input  wire logic          i_inflight,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_ready,
    output tps_pkg::t_out      o_item
);
    import tps_pkg::*;

    t_out       r_buf [RESQ_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;
    logic [2:0] committed;

    assign pop       = o_valid && i_ready;
    assign o_valid   = (r_count != 2'd0);
    assign o_item    = r_buf[r_rd_ptr];
    // A word still being finished upstream has a place reserved.
    assign committed = 3'(r_count) + 3'(i_inflight);
    assign o_room    = (committed < 3'(RESQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == 2'(RESQ_DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'(RESQ_DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `TPS_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && !pop && (r_count == 2'(RESQ_DEPTH))), "result queue overflow")
    `TPS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= 2'(RESQ_DEPTH), "result queue count out of range")

endmodule

`default_nettype wire

FILE: sv/timed_playlist_sequencer.sv
// Top level of the timed playlist sequencer: control, slot RAM and result queue.
// Depends on tps_pkg, tps_ctrl, tps_slot_ram and tps_result_q.
`default_nettype none

// A table of up to min(DEPTH, 256) slots (plugin id, dwell in ms) stepped by
// add, clear, start, stop and tick words; every input word yields one result
// word. The block takes one word per clock cycle sustained while the output
// accepts results: each word is processed in the cycle it is accepted, and the
// dwell of the current slot comes from a registered slot RAM read that is
// addressed with the next position (with write forwarding), so back-to-back
// ticks see the right slot. A result word is registered in the control block
// and then written into a three-word result queue that absorbs output
// back-pressure; input ready drops only when that queue and the word in flight
// fill it. Input ready is held low while reset is asserted. The slot table
// needs no clearing pass after reset: only slots under the fill count are used.
module timed_playlist_sequencer #(
    parameter int DEPTH = tps_pkg::DEPTH_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tps_pkg::t_in  i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tps_pkg::t_out      o_out_item
);
    import tps_pkg::*;

    localparam int ENTRIES = (DEPTH < HARD_LIMIT) ? DEPTH : HARD_LIMIT;
    localparam int AW      = addr_w(ENTRIES);

    logic          fire;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_slot         wdata;
    t_slot         rdata;
    logic          res_valid;
    t_out          res;
    logic          room;

    assign o_in_ready = room && i_rst_n;
    assign fire       = i_in_valid && o_in_ready;

    tps_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (i_in_item),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tps_slot_ram #(
        .ENTRIES (ENTRIES),
        .WIDTH   ($bits(t_slot))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tps_result_q u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_item (res),
        .i_inflight  (res_valid),
        .o_room      (room),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire
